@@ rtl/fakws_pkg.sv @@
// Shared types, register indexes and mixing functions of the address-keyed word scrambler.
package fakws_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD1      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD2      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD3      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTITION_BASE = 3'd4;

    localparam logic [31:0] KEY_WORD0_RST      = 32'h510F_B093;
    localparam logic [31:0] KEY_WORD1_RST      = 32'hA3CB_EADC;
    localparam logic [31:0] KEY_WORD2_RST      = 32'h5993_A17E;
    localparam logic [31:0] KEY_WORD3_RST      = 32'hC7AD_EB03;
    localparam logic [31:0] PARTITION_BASE_RST = 32'h0000_0000;

    localparam logic [15:0] S15_TAP_MASK = 16'h6371;
    localparam logic [16:0] S16_TAP_MASK = 17'h1_3659;
    localparam logic [31:0] S32_TAP_MASK = 32'hE519_A4F1;

    localparam logic [7:0] GLOBAL_OFF_LO = 8'h00;
    localparam logic [7:0] GLOBAL_OFF_HI = 8'hFF;

    typedef struct packed {
        logic [31:0] key_word0;
        logic [31:0] key_word1;
        logic [31:0] key_word2;
        logic [31:0] key_word3;
        logic [31:0] partition_base;
    } t_cfg;

    function automatic logic [15:0] stage15(input logic [15:0] v);
        logic [15:0] a;
        logic [10:0] x;
        logic [15:0] b;
        a = {v[6:0], 9'b0} + {7'b0, v[15:7]};
        x = v[15:5];
        b = {x[3:0], 12'b0} + {4'b0, x[3:0], 8'b0} + {8'b0, x[3:0], 4'b0}
            + {12'b0, x[3:0]};
        return a ^ (b & S15_TAP_MASK);
    endfunction

    function automatic logic [15:0] stage16(input logic [16:0] v);
        logic [16:0] a;
        logic [3:0]  s;
        logic [16:0] b;
        a = {v[9:0], v[16:10]};
        s = {v[1], v[5], v[9], v[13]};
        b = {v[4], s, s, s, s} & S16_TAP_MASK;
        return a[15:0] ^ b[15:0];
    endfunction

    function automatic logic [31:0] stage32(input logic [31:0] v);
        logic [31:0] rep;
        rep = {8{v[5:2]}};
        return {v[14:0], v[31:15]} ^ (rep & S32_TAP_MASK);
    endfunction

endpackage

@@ rtl/flash_address_keyed_word_scrambler.sv @@
// Top level of the flash address-keyed word scrambler.
// An accepted word passes three pipeline registers (address, stage input,
// output); throughput is one word per cycle while i_stall is low.
// Reset: synchronous active-low i_rst_n empties the pipeline and restores
// the key words and partition base to their defaults.
module flash_address_keyed_word_scrambler
    import fakws_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [31:0]          i_byte_offset,
    input  logic [31:0]          i_data_word,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [31:0]          o_scrambled_word
);

    t_cfg cfg;

    fakws_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    fakws_pipe u_pipe (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_byte_offset    (i_byte_offset),
        .i_data_word      (i_data_word),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_scrambled_word (o_scrambled_word)
    );

endmodule

@@ rtl/fakws_regs.sv @@
// Key and partition base registers written through the configuration channel.
module fakws_regs
    import fakws_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KEY_WORD0:      n_cfg.key_word0      = i_cfg_data;
                CFG_KEY_WORD1:      n_cfg.key_word1      = i_cfg_data;
                CFG_KEY_WORD2:      n_cfg.key_word2      = i_cfg_data;
                CFG_KEY_WORD3:      n_cfg.key_word3      = i_cfg_data;
                CFG_PARTITION_BASE: n_cfg.partition_base = i_cfg_data;
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_word0      <= KEY_WORD0_RST;
            r_cfg.key_word1      <= KEY_WORD1_RST;
            r_cfg.key_word2      <= KEY_WORD2_RST;
            r_cfg.key_word3      <= KEY_WORD3_RST;
            r_cfg.partition_base <= PARTITION_BASE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ rtl/fakws_pipe.sv @@
// Three-stage scramble pipeline: address add, stage input forming, mixing and output XOR.
module fakws_pipe
    import fakws_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_byte_offset,
    input  logic [31:0] i_data_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_scrambled_word
);

    logic        en1, en2, en3;
    logic        all_off;
    logic [7:0]  top_byte;

    logic        r_v1, r_v2, r_v3;
    logic [31:0] r_addr, r_data1;
    logic [15:0] r_in15;
    logic [16:0] r_in16;
    logic [31:0] r_in32, r_data2;
    logic [31:0] r_out;

    logic [15:0] hi_sel, lo_sel, n_in15;
    logic [31:0] shifted, rot, n_in32;
    logic [16:0] k16, n_in16;
    logic [31:0] mask, n_out;

    // bubbles collapse: a stage loads when it is empty or moving on
    assign en3     = !r_v3 || !i_stall;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;
    assign o_valid = r_v3;
    assign o_scrambled_word = r_out;

    assign top_byte = i_cfg.key_word3[31:24];
    assign all_off  = (top_byte == GLOBAL_OFF_LO) || (top_byte == GLOBAL_OFF_HI);

    // stage 2 inputs
    always_comb begin
        hi_sel  = i_cfg.key_word3[6] ? {r_addr[23:16], r_addr[31:24]} : r_addr[31:16];
        lo_sel  = i_cfg.key_word3[5] ? {r_addr[7:0], r_addr[15:8]} : r_addr[15:0];
        n_in15  = i_cfg.key_word1[31:16] ^ hi_sel ^ lo_sel;
        shifted = r_addr >> i_cfg.key_word3[9:8];
        k16     = {i_cfg.key_word1[15:8], i_cfg.key_word3[4], i_cfg.key_word1[7:0]};
        n_in16  = k16 ^ shifted[16:0];
        unique case (i_cfg.key_word3[12:11])
            2'd0:    rot = r_addr;
            2'd1:    rot = {r_addr[7:0], r_addr[31:8]};
            2'd2:    rot = {r_addr[15:0], r_addr[31:16]};
            default: rot = {r_addr[23:0], r_addr[31:24]};
        endcase
        n_in32 = i_cfg.key_word0 ^ rot;
    end

    // stage 3 mixing
    always_comb begin
        mask = '0;
        if (!(all_off || i_cfg.key_word3[0])) mask[31:16] = stage15(r_in15);
        if (!(all_off || i_cfg.key_word3[1])) mask[15:0]  = stage16(r_in16);
        if (!(all_off || i_cfg.key_word3[2])) mask = mask ^ stage32(r_in32);
        if (!(all_off || i_cfg.key_word3[3])) mask = mask ^ i_cfg.key_word2;
        n_out = r_data2 ^ mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_addr  <= i_cfg.partition_base + i_byte_offset;
            r_data1 <= i_data_word;
        end
        if (en2) begin
            r_in15  <= n_in15;
            r_in16  <= n_in16;
            r_in32  <= n_in32;
            r_data2 <= r_data1;
        end
        if (en3) begin
            r_out <= n_out;
        end
    end

endmodule
